// ===== src/dnsq_pkg.sv =====
// Package for the day/night switch qualifier: register indexes, event codes,
// configuration and state structs, and the gain code divide-by-1000 helper.
// No dependencies.
`default_nettype none

package dnsq_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_DAY_THRESHOLD    = 3'd0,
		REG_NIGHT_THRESHOLD  = 3'd1,
		REG_SENSOR_CONFIRM   = 3'd2,
		REG_CODE_FORCE_DAY   = 3'd3,
		REG_CODE_FORCE_NIGHT = 3'd4,
		REG_CODE_GAIN_AUTO   = 3'd5
	} cfg_reg_t;

	// switch event codes
	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_TO_DAY   = 2'd1,
		EV_TO_NIGHT = 2'd2
	} switch_ev_t;

	localparam int SAMPLE_W   = 10;
	localparam int GAIN_W     = 14;
	localparam int LEVEL_W    = 8;
	localparam int CODE_W     = 5;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [GAIN_W-1:0]  GAIN_MODE_LIMIT   = GAIN_W'(999);
	localparam logic [GAIN_W-1:0]  GAIN_MODE_DIV     = GAIN_W'(1000);
	localparam logic [LEVEL_W-1:0] GAIN_AUTO_CONFIRM = LEVEL_W'(100);

	// reciprocal of 1000 scaled by 2^24, rounded up; exact for 14-bit codes
	localparam int RECIP_SHIFT = 24;
	localparam logic [14:0] RECIP_1000 = 15'd16778;

	typedef struct packed {
		logic [LEVEL_W-1:0] day_threshold;
		logic [LEVEL_W-1:0] night_threshold;
		logic [LEVEL_W-1:0] sensor_confirm_count;
		logic [CODE_W-1:0]  code_force_day;
		logic [CODE_W-1:0]  code_force_night;
		logic [CODE_W-1:0]  code_gain_auto;
	} dnsq_cfg_t;

	typedef struct packed {
		logic               night_mode;
		logic [LEVEL_W-1:0] qualify_count;
		logic [LEVEL_W-1:0] previous_level;
	} dnsq_state_t;

	// thousands value of a gain code (0..16)
	function automatic logic [CODE_W-1:0] gain_thousands(input logic [GAIN_W-1:0] gain);
		logic [GAIN_W+15-1:0] prod;
		prod = {15'd0, gain} * {{GAIN_W{1'b0}}, RECIP_1000};
		return CODE_W'(prod >> RECIP_SHIFT);
	endfunction

endpackage

`default_nettype wire

// ===== src/dnsq_if.sv =====
// Valid/ready channel interfaces for the day/night switch qualifier:
// the sensor tick word in and the result word out. Depends on dnsq_pkg.
`default_nettype none

interface dnsq_in_if
	import dnsq_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sensor_sample;
	logic                sample_ok;
	logic [GAIN_W-1:0]   gain_code;

	modport source (output valid, output sensor_sample, output sample_ok,
		output gain_code, input ready);
	modport sink (input valid, input sensor_sample, input sample_ok,
		input gain_code, output ready);
endinterface

interface dnsq_out_if
	import dnsq_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               is_night;
	logic [1:0]         switch_event;
	logic [LEVEL_W-1:0] confirm_progress;

	modport source (output valid, output is_night, output switch_event,
		output confirm_progress, input ready);
	modport sink (input valid, input is_night, input switch_event,
		input confirm_progress, output ready);
endinterface

`default_nettype wire

// ===== src/dnsq_step.sv =====
// One tick of the day/night qualifier: gain code decode, level select,
// hysteresis compare and confirm counting. Combinational. Depends on dnsq_pkg.
`default_nettype none

module dnsq_step
	import dnsq_pkg::*;
(
	input  wire dnsq_cfg_t         cfg,
	input  wire dnsq_state_t       cur,
	input  wire [SAMPLE_W-1:0]     sensor_sample,
	input  wire                    sample_ok,
	input  wire [GAIN_W-1:0]       gain_code,
	output dnsq_state_t            nxt,
	output switch_ev_t             ev
);

	logic [CODE_W-1:0]  mode;
	logic [GAIN_W-1:0]  mode_x1000;
	logic [LEVEL_W-1:0] rest_lo;
	logic               coded;
	logic               is_fday, is_fnight, is_auto;
	logic [LEVEL_W-1:0] level;
	logic [LEVEL_W-1:0] confirm;
	logic [LEVEL_W-1:0] cnt_inc;
	logic               do_qualify;

	assign mode       = gain_thousands(gain_code);
	assign mode_x1000 = GAIN_W'({{(GAIN_W-CODE_W){1'b0}}, mode} * GAIN_MODE_DIV);
	// only the low byte of the remainder matters
	assign rest_lo    = gain_code[LEVEL_W-1:0] - mode_x1000[LEVEL_W-1:0];
	assign coded      = gain_code > GAIN_MODE_LIMIT;

	// first match wins when codes coincide
	assign is_fday    = coded && (mode == cfg.code_force_day);
	assign is_fnight  = coded && !is_fday && (mode == cfg.code_force_night);
	assign is_auto    = coded && !is_fday && !is_fnight && (mode == cfg.code_gain_auto);

	assign level      = coded ? rest_lo : sensor_sample[SAMPLE_W-1:2];
	assign confirm    = coded ? GAIN_AUTO_CONFIRM : cfg.sensor_confirm_count;
	assign cnt_inc    = cur.qualify_count + LEVEL_W'(1);
	assign do_qualify = sample_ok && (!coded || is_auto);

	always_comb begin
		nxt = cur;
		ev  = EV_NONE;
		if (sample_ok && is_fday) begin
			if (cur.night_mode) begin
				nxt.night_mode = 1'b0;
				ev             = EV_TO_DAY;
			end
		end else if (sample_ok && is_fnight) begin
			if (!cur.night_mode) begin
				nxt.night_mode = 1'b1;
				ev             = EV_TO_NIGHT;
			end
		end else if (do_qualify) begin
			nxt.previous_level = level;
			if (cur.night_mode && (level < cfg.day_threshold)) begin
				if (cur.previous_level < cfg.day_threshold) begin
					nxt.qualify_count = cnt_inc;
					if (cnt_inc > confirm) begin
						nxt.qualify_count = '0;
						nxt.night_mode    = 1'b0;
						ev                = EV_TO_DAY;
					end
				end else begin
					nxt.qualify_count = LEVEL_W'(1);
				end
			end else if (!cur.night_mode && (level > cfg.night_threshold)) begin
				if (cur.previous_level > cfg.night_threshold) begin
					nxt.qualify_count = cnt_inc;
					if (cnt_inc > confirm) begin
						nxt.qualify_count = '0;
						nxt.night_mode    = 1'b1;
						ev                = EV_TO_NIGHT;
					end
				end else begin
					nxt.qualify_count = LEVEL_W'(1);
				end
			end else begin
				nxt.qualify_count = '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/day_night_switch_qualifier_unit.sv =====
// Day/night switch qualifier top level: input stage, state and config
// registers, result register. Depends on dnsq_pkg, dnsq_if.sv, dnsq_step.
//
// Usage:
//   in_ch  : one word per sensor tick (sensor_sample, sample_ok, gain_code),
//            valid/ready, taken when both are high.
//   out_ch : one result word per tick (is_night, switch_event,
//            confirm_progress), valid/ready.
//   cfg_*  : register write port; cfg_addr selects the register in list
//            order, write while no tick is in flight.
// A taken word goes through the input stage, then the result register, to out_ch.
// Throughput: one word per cycle when out_ch is not stalled; the tick update
// is a single pass of compare/count logic, and the divide by 1000 is a 15-bit
// constant multiply. A stalled receiver holds the result register; one more
// word can sit in the input stage, after which in_ch.ready drops until out_ch
// drains. Reset clears all state to day mode with counter and previous level
// zero, loads the register defaults and empties both stages.
`default_nettype none

module day_night_switch_qualifier_unit
	import dnsq_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_wr_en,
	input  wire [CFG_ADDR_W-1:0] cfg_addr,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	dnsq_in_if.sink              in_ch,
	dnsq_out_if.source           out_ch
);

	dnsq_cfg_t           cfg_q;
	dnsq_state_t         state_q;
	dnsq_state_t         state_nxt;
	switch_ev_t          ev;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                ok_s1;
	logic [GAIN_W-1:0]   gain_s1;

	logic                out_valid_q;
	logic                is_night_q;
	logic [1:0]          event_q;
	logic [LEVEL_W-1:0]  progress_q;

	logic                advance;

	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.day_threshold        <= LEVEL_W'(64);
			cfg_q.night_threshold      <= LEVEL_W'(192);
			cfg_q.sensor_confirm_count <= LEVEL_W'(20);
			cfg_q.code_force_day       <= CODE_W'(1);
			cfg_q.code_force_night     <= CODE_W'(2);
			cfg_q.code_gain_auto       <= CODE_W'(3);
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_DAY_THRESHOLD:    cfg_q.day_threshold        <= cfg_data;
				REG_NIGHT_THRESHOLD:  cfg_q.night_threshold      <= cfg_data;
				REG_SENSOR_CONFIRM:   cfg_q.sensor_confirm_count <= cfg_data;
				REG_CODE_FORCE_DAY:   cfg_q.code_force_day       <= cfg_data[CODE_W-1:0];
				REG_CODE_FORCE_NIGHT: cfg_q.code_force_night     <= cfg_data[CODE_W-1:0];
				REG_CODE_GAIN_AUTO:   cfg_q.code_gain_auto       <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			sample_s1 <= in_ch.sensor_sample;
			ok_s1     <= in_ch.sample_ok;
			gain_s1   <= in_ch.gain_code;
		end
	end

	dnsq_step u_step (
		.cfg           (cfg_q),
		.cur           (state_q),
		.sensor_sample (sample_s1),
		.sample_ok     (ok_s1),
		.gain_code     (gain_s1),
		.nxt           (state_nxt),
		.ev            (ev)
	);

	// qualifier state moves only when the tick leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			is_night_q <= state_nxt.night_mode;
			event_q    <= ev;
			progress_q <= state_nxt.qualify_count;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.is_night         = is_night_q;
	assign out_ch.switch_event     = event_q;
	assign out_ch.confirm_progress = progress_q;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for day_night_switch_qualifier_unit: directed and random sensor ticks,
// each result word checked against a behavioral model of the qualifier.
// Depends on dnsq_pkg, dnsq_if.sv and the RTL of the unit.
module testbench;
	import dnsq_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_TICKS = 1100;
	localparam int PHASE_TICKS  = 220;
	localparam int MAX_WAIT     = 16;

	typedef struct packed {
		logic               is_night;
		switch_ev_t         ev;
		logic [LEVEL_W-1:0] progress;
	} dn_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_data;

	dnsq_in_if  in_ch ();
	dnsq_out_if out_ch ();

	day_night_switch_qualifier_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// model of the qualifier, advanced once per accepted word
	dnsq_cfg_t          cfg_shadow;
	logic               night_now;
	logic [LEVEL_W-1:0] qual_count;
	logic [LEVEL_W-1:0] last_level;
	dn_result_t         pending_results[$];

	int errors;
	int cycles = 0;
	int ok_ticks;
	int out_hold;
	bit no_idle;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic switch_ev_t qualify_level(input logic [LEVEL_W-1:0] level,
		input logic [LEVEL_W-1:0] confirm);
		switch_ev_t ev;
		ev = EV_NONE;
		if (night_now && level < cfg_shadow.day_threshold) begin
			if (last_level < cfg_shadow.day_threshold) begin
				qual_count = qual_count + 8'd1;
				if (qual_count > confirm) begin
					qual_count = '0;
					night_now = 1'b0;
					ev = EV_TO_DAY;
				end
			end else begin
				qual_count = 8'd1;
			end
		end else if (!night_now && level > cfg_shadow.night_threshold) begin
			if (last_level > cfg_shadow.night_threshold) begin
				qual_count = qual_count + 8'd1;
				if (qual_count > confirm) begin
					qual_count = '0;
					night_now = 1'b1;
					ev = EV_TO_NIGHT;
				end
			end else begin
				qual_count = 8'd1;
			end
		end else begin
			qual_count = '0;
		end
		last_level = level;
		return ev;
	endfunction

	function automatic dn_result_t advance_day_night(input logic [SAMPLE_W-1:0] sample,
		input logic ok, input logic [GAIN_W-1:0] gain);
		dn_result_t r;
		int thousands;
		logic [LEVEL_W-1:0] auto_level;
		r.ev = EV_NONE;
		if (ok) begin
			if (gain > GAIN_MODE_LIMIT) begin
				thousands = int'(gain) / int'(GAIN_MODE_DIV);
				auto_level = LEVEL_W'(int'(gain) % int'(GAIN_MODE_DIV));
				// first match wins when codes coincide
				if (thousands == int'(cfg_shadow.code_force_day)) begin
					if (night_now) begin
						night_now = 1'b0;
						r.ev = EV_TO_DAY;
					end
				end else if (thousands == int'(cfg_shadow.code_force_night)) begin
					if (!night_now) begin
						night_now = 1'b1;
						r.ev = EV_TO_NIGHT;
					end
				end else if (thousands == int'(cfg_shadow.code_gain_auto)) begin
					r.ev = qualify_level(auto_level, GAIN_AUTO_CONFIRM);
				end
			end else begin
				r.ev = qualify_level(sample[SAMPLE_W-1:2], cfg_shadow.sensor_confirm_count);
			end
		end
		r.is_night = night_now;
		r.progress = qual_count;
		return r;
	endfunction

	// result side: random stalls, compare each word with the oldest prediction
	always @(posedge clk) begin
		dn_result_t exp_w;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result word with no tick pending");
					errors++;
				end else begin
					exp_w = pending_results.pop_front();
					if (out_ch.is_night !== exp_w.is_night) begin
						$error("is_night mismatch: expected %0d, actual %0d",
							exp_w.is_night, out_ch.is_night);
						errors++;
					end
					if (out_ch.switch_event !== exp_w.ev) begin
						$error("switch_event mismatch: expected %0d, actual %0d",
							exp_w.ev, out_ch.switch_event);
						errors++;
					end
					if (out_ch.confirm_progress !== exp_w.progress) begin
						$error("confirm_progress mismatch: expected %0d, actual %0d",
							exp_w.progress, out_ch.confirm_progress);
						errors++;
					end
				end
				out_hold = no_idle ? 0 : $urandom_range(MAX_WAIT, 0);
			end
			if (out_hold > 0) begin
				out_ch.ready <= 1'b0;
				out_hold = out_hold - 1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Called at a rising edge; returns at the edge that took the word.
	// valid stays high so a back-to-back word needs no second assignment.
	task automatic send_tick(input logic [SAMPLE_W-1:0] sample, input logic ok,
		input logic [GAIN_W-1:0] gain);
		int gap;
		gap = no_idle ? 0 : $urandom_range(MAX_WAIT, 0);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.sensor_sample <= sample;
		in_ch.sample_ok     <= ok;
		in_ch.gain_code     <= gain;
		do @(posedge clk); while (!in_ch.ready);
		pending_results.push_back(advance_day_night(sample, ok, gain));
		if (ok)
			ok_ticks++;
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic apply_settings(input dnsq_cfg_t c);
		write_reg(REG_DAY_THRESHOLD, c.day_threshold);
		write_reg(REG_NIGHT_THRESHOLD, c.night_threshold);
		write_reg(REG_SENSOR_CONFIRM, c.sensor_confirm_count);
		write_reg(REG_CODE_FORCE_DAY, CFG_DATA_W'(c.code_force_day));
		write_reg(REG_CODE_FORCE_NIGHT, CFG_DATA_W'(c.code_force_night));
		write_reg(REG_CODE_GAIN_AUTO, CFG_DATA_W'(c.code_gain_auto));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		cfg_shadow = c;
	endtask

	task automatic test_directed();
		apply_settings('{8'd64, 8'd192, 8'd1, 5'd1, 5'd2, 5'd3});
		send_tick(10'h3FF, 1'b0, 14'h3FFF);   // failed read: no-op
		send_tick(10'h000, 1'b1, 14'd0);
		send_tick(10'h3FF, 1'b1, 14'd999);    // first qualifying tick
		send_tick(10'h3FF, 1'b1, 14'd0);      // count passes confirm: to night
		send_tick(10'h000, 1'b0, 14'd2000);
		send_tick(10'h000, 1'b1, 14'd999);
		send_tick(10'h003, 1'b1, 14'd500);    // back to day
		send_tick(10'h2AA, 1'b1, 14'd1000);   // forced day while already day
		send_tick(10'h155, 1'b1, 14'd2999);   // forced night
		send_tick(10'h000, 1'b1, 14'd2000);
		send_tick(10'h3FF, 1'b1, 14'd16383);  // unknown thousands value
		send_tick(10'h3FF, 1'b1, 14'd4000);
		send_tick(10'h000, 1'b1, 14'd1999);   // forced day
		send_tick(10'h000, 1'b1, 14'd3255);
		send_tick(10'h000, 1'b1, 14'd3256);   // remainder 256 folds to level 0
		send_tick(10'h000, 1'b1, 14'd3999);   // remainder 999 gives level 231
		send_tick(10'h3FF, 1'b1, 14'd3999);
		send_tick(10'h3FF, 1'b1, 14'd900);    // sensor mode picks up the count
		wait_idle();
	endtask

	task automatic test_shared_codes();
		apply_settings('{8'd64, 8'd192, 8'd1, 5'd5, 5'd5, 5'd5});
		send_tick(10'h000, 1'b1, 14'd5500);   // all codes equal: forced day wins
		wait_idle();
		apply_settings('{8'd64, 8'd192, 8'd1, 5'd0, 5'd16, 5'd16});
		send_tick(10'h000, 1'b1, 14'd16000);  // forced night beats gain-auto
		send_tick(10'h3FF, 1'b1, 14'd16383);
		send_tick(10'h3FF, 1'b1, 14'd0);      // code 0 never applies below 1000
		wait_idle();
		apply_settings('{8'd64, 8'd192, 8'd1, 5'd0, 5'd7, 5'd16});
		send_tick(10'h000, 1'b1, 14'd16255);
		send_tick(10'h000, 1'b1, 14'd16010);
		send_tick(10'h000, 1'b1, 14'd16010);
		wait_idle();
	endtask

	// One run: mostly a stretch of levels pushing toward a switch,
	// sometimes cut short; otherwise forced codes or raw noise.
	task automatic drive_run();
		int kind, len, confirm, code, rest, top;
		bit use_auto, to_night;
		logic [LEVEL_W-1:0] level;
		kind = $urandom_range(9, 0);
		use_auto = (kind == 6 || kind == 7) && cfg_shadow.code_gain_auto != 0
			&& cfg_shadow.code_gain_auto != cfg_shadow.code_force_day
			&& cfg_shadow.code_gain_auto != cfg_shadow.code_force_night;
		to_night = ($urandom_range(9, 0) != 0) ? !night_now : night_now;
		confirm = use_auto ? int'(GAIN_AUTO_CONFIRM) : int'(cfg_shadow.sensor_confirm_count);
		len = ($urandom_range(3, 0) == 0) ? $urandom_range(confirm, 1)
			: confirm + 1 + $urandom_range(3, 0);
		if (kind == 8) begin
			code = $urandom_range(1, 0) ? cfg_shadow.code_force_day : cfg_shadow.code_force_night;
			top = (code == 16) ? 383 : 999;
			send_tick(SAMPLE_W'($urandom), 1'b1, GAIN_W'(code * 1000 + $urandom_range(top, 0)));
		end else if (kind == 9) begin
			repeat ($urandom_range(5, 1))
				send_tick(SAMPLE_W'($urandom), 1'($urandom), GAIN_W'($urandom));
		end else begin
			repeat (len) begin
				if ($urandom_range(9, 0) == 0)
					send_tick(SAMPLE_W'($urandom), 1'b0, GAIN_W'($urandom));
				if (to_night)
					level = (cfg_shadow.night_threshold == 8'hFF) ? LEVEL_W'($urandom)
						: LEVEL_W'($urandom_range(255, int'(cfg_shadow.night_threshold) + 1));
				else
					level = (cfg_shadow.day_threshold == 8'h00) ? LEVEL_W'($urandom)
						: LEVEL_W'($urandom_range(int'(cfg_shadow.day_threshold) - 1, 0));
				if (use_auto) begin
					code = cfg_shadow.code_gain_auto;
					top = (code == 16) ? 383 : 999;
					// any remainder whose low byte is the level
					rest = int'(level) + 256 * $urandom_range((top - int'(level)) / 256, 0);
					send_tick(SAMPLE_W'($urandom), 1'b1, GAIN_W'(code * 1000 + rest));
				end else begin
					send_tick({level, 2'($urandom)}, 1'b1, GAIN_W'($urandom_range(999, 0)));
				end
			end
		end
	endtask

	task automatic test_random_runs();
		dnsq_cfg_t c;
		int phase, start, target;
		phase = 0;
		start = ok_ticks;
		while (ok_ticks - start < RANDOM_TICKS) begin
			c.day_threshold        = LEVEL_W'($urandom_range(128, 16));
			c.night_threshold      = LEVEL_W'($urandom_range(240, 128));
			c.sensor_confirm_count = LEVEL_W'($urandom_range(24, 1));
			c.code_force_day       = CODE_W'($urandom_range(16, 0));
			c.code_force_night     = CODE_W'($urandom_range(16, 0));
			c.code_gain_auto       = CODE_W'($urandom_range(16, 1));
			case (phase)
			0: c = '{8'd64, 8'd192, 8'd20, 5'd1, 5'd2, 5'd3};
			1: c = '{8'd255, 8'd0, 8'd1, 5'd0, 5'd16, 5'd15};
			2: c = '{8'd0, 8'd255, 8'd254, 5'd16, 5'd0, 5'd1};
			3: begin
				c.sensor_confirm_count = 8'd254;
				c.code_gain_auto = 5'd16;
			end
			default: ;
			endcase
			wait_idle();
			apply_settings(c);
			target = ok_ticks + PHASE_TICKS;
			while (ok_ticks < target) begin
				no_idle = ($urandom_range(4, 0) == 0);
				drive_run();
				if ($urandom_range(15, 0) == 0)
					wait_idle();
			end
			phase++;
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_addr            = '0;
		cfg_data            = '0;
		in_ch.valid         = 1'b0;
		in_ch.sensor_sample = '0;
		in_ch.sample_ok     = 1'b0;
		in_ch.gain_code     = '0;
		out_ch.ready        = 1'b0;
		errors              = 0;
		ok_ticks            = 0;
		out_hold            = 0;
		no_idle             = 1'b0;
		cfg_shadow          = '{8'd64, 8'd192, 8'd20, 5'd1, 5'd2, 5'd3};
		night_now           = 1'b0;
		qual_count          = '0;
		last_level          = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_shared_codes();
		test_random_runs();
		wait_idle();
		repeat (4) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/dnsq_pkg.sv
src/dnsq_if.sv
src/dnsq_step.sv
src/day_night_switch_qualifier_unit.sv
bench/testbench.sv
